[rtl/core/etl_pkg.sv]
// ----------------------------------------------------------------------------
// etl_pkg
// Shared types, codes and character-class helpers for the expression lexer.
// ----------------------------------------------------------------------------
package etl_pkg;

  // lexer mode between characters
  typedef enum logic [3:0] {
    M_IDLE = 4'd0,
    M_ZERO = 4'd1,
    M_HEX0 = 4'd2,
    M_HEX  = 4'd3,
    M_OCT0 = 4'd4,
    M_OCT  = 4'd5,
    M_BIN0 = 4'd6,
    M_BIN  = 4'd7,
    M_DEC  = 4'd8,
    M_NAME = 4'd9,
    M_ERR  = 4'd10
  } mode_e;

  typedef enum logic [3:0] {
    K_NUM    = 4'd0,
    K_NAME   = 4'd1,
    K_LPAREN = 4'd2,
    K_RPAREN = 4'd3,
    K_ADD    = 4'd4,
    K_SUB    = 4'd5,
    K_MUL    = 4'd6,
    K_DIV    = 4'd7,
    K_MOD    = 4'd8,
    K_ASSIGN = 4'd9,
    K_SEMI   = 4'd10,
    K_AT     = 4'd11,
    K_END    = 4'd12,
    K_ERROR  = 4'd13
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_HEX    = 3'd1,
    ERR_OCT    = 3'd2,
    ERR_BIN    = 3'd3,
    ERR_PREFIX = 3'd4,
    ERR_CHAR   = 3'd5
  } err_e;

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  number_value;
    logic [15:0]  name_start;
    logic [15:0]  name_length;
    err_e         error_kind;
    logic         last;
  } tok_t;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } op_t;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  function automatic logic is_dig(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // letter digits fold case with the 0x5F mask, then drop the 'A'-10 offset
  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] v;
    if (is_dig(c)) begin
      v = c & 8'h0F;
    end else begin
      v = (c & 8'h5F) - 8'd55;
    end
    return v[3:0];
  endfunction

  function automatic op_t op_lookup(logic [7:0] c);
    op_t r;
    r.hit  = 1'b1;
    r.kind = K_END;
    case (c)
      "(":     r.kind = K_LPAREN;
      ")":     r.kind = K_RPAREN;
      "+":     r.kind = K_ADD;
      "-":     r.kind = K_SUB;
      "*":     r.kind = K_MUL;
      "/":     r.kind = K_DIV;
      "%":     r.kind = K_MOD;
      "=":     r.kind = K_ASSIGN;
      ";":     r.kind = K_SEMI;
      "@":     r.kind = K_AT;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tok_t mk_tok(kind_e k, logic [63:0] num, logic [15:0] st,
                                  logic [15:0] len, err_e e);
    tok_t t;
    t.kind         = k;
    t.number_value = num;
    t.name_start   = st;
    t.name_length  = len;
    t.error_kind   = e;
    t.last         = 1'b0;
    return t;
  endfunction

endpackage

[rtl/core/etl_if.sv]
// ----------------------------------------------------------------------------
// etl_if
// Valid/ready channels: character words in, token words out.
// ----------------------------------------------------------------------------
interface etl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface etl_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] number_value;
  logic [15:0] name_start;
  logic [15:0] name_length;
  logic [2:0]  error_kind;
  logic        last;

  modport source (output valid, output token_kind, output number_value,
                  output name_start, output name_length, output error_kind,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input name_start, input name_length, input error_kind,
                  input last, output ready);
endinterface

[rtl/core/etl_step.sv]
// ----------------------------------------------------------------------------
// etl_step
// One character of lexing: next mode/accumulator/position and up to two tokens.
// ----------------------------------------------------------------------------
module etl_step import etl_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  mode_e                     mode_i,
  input  logic [63:0]               acc_i,
  input  logic [POSITION_WIDTH-1:0] pos_i,
  input  logic [POSITION_WIDTH-1:0] start_i,
  input  logic [7:0]                ch_i,
  output mode_e                     mode_o,
  output logic [63:0]               acc_o,
  output logic [POSITION_WIDTH-1:0] pos_o,
  output logic [POSITION_WIDTH-1:0] start_o,
  output logic [1:0]                cnt_o,
  output tok_t                      tok_o [2]
);

  localparam logic [POSITION_WIDTH-1:0] PosMax = '1;

  logic [31:0] start_ext;
  logic [31:0] len_ext;
  logic        reproc;
  logic        name_ch;
  op_t         op;

  assign start_ext = 32'(start_i);
  assign len_ext   = 32'(pos_i - start_i);
  assign name_ch   = is_alpha(ch_i) || is_dig(ch_i) || (ch_i == "_");
  assign op        = op_lookup(ch_i);

  always_comb begin
    mode_o  = mode_i;
    acc_o   = acc_i;
    start_o = start_i;
    pos_o   = pos_i;
    reproc  = 1'b0;
    cnt_o   = 2'd0;
    tok_o[0] = '0;
    tok_o[1] = '0;

    case (mode_i)
      M_ZERO: begin
        if (ch_i == "x" || ch_i == "X") begin
          mode_o = M_HEX0;
        end else if (ch_i == "b" || ch_i == "B") begin
          mode_o = M_BIN0;
        end else if (ch_i == "o" || ch_i == "O") begin
          mode_o = M_OCT0;
        end else begin
          tok_o[0] = mk_tok(K_ERROR, '0, '0, '0, ERR_PREFIX);
          cnt_o = 2'd1; mode_o = M_ERR; acc_o = '0;
        end
      end
      M_HEX0: begin
        if (is_hex(ch_i)) begin
          acc_o = 64'(hex_val(ch_i)); mode_o = M_HEX;
        end else begin
          tok_o[0] = mk_tok(K_ERROR, '0, '0, '0, ERR_HEX);
          cnt_o = 2'd1; mode_o = M_ERR; acc_o = '0;
        end
      end
      M_OCT0: begin
        if (ch_i >= "0" && ch_i <= "7") begin
          acc_o = 64'(ch_i[2:0]); mode_o = M_OCT;
        end else begin
          tok_o[0] = mk_tok(K_ERROR, '0, '0, '0, ERR_OCT);
          cnt_o = 2'd1; mode_o = M_ERR; acc_o = '0;
        end
      end
      M_BIN0: begin
        if (ch_i == "0" || ch_i == "1") begin
          acc_o = 64'(ch_i[0]); mode_o = M_BIN;
        end else begin
          tok_o[0] = mk_tok(K_ERROR, '0, '0, '0, ERR_BIN);
          cnt_o = 2'd1; mode_o = M_ERR; acc_o = '0;
        end
      end
      M_HEX, M_OCT, M_BIN, M_DEC: begin
        if (mode_i == M_HEX && is_hex(ch_i)) begin
          acc_o = (acc_i << 4) + 64'(hex_val(ch_i));
        end else if (mode_i == M_OCT && ch_i >= "0" && ch_i <= "7") begin
          acc_o = (acc_i << 3) + 64'(ch_i[2:0]);
        end else if (mode_i == M_BIN && (ch_i == "0" || ch_i == "1")) begin
          acc_o = (acc_i << 1) + 64'(ch_i[0]);
        end else if (mode_i == M_DEC && is_dig(ch_i)) begin
          // times ten as two shifts
          acc_o = (acc_i << 3) + (acc_i << 1) + 64'(ch_i[3:0]);
        end else begin
          tok_o[0] = mk_tok(K_NUM, acc_i, '0, '0, ERR_NONE);
          cnt_o = 2'd1; acc_o = '0; mode_o = M_IDLE; reproc = 1'b1;
        end
      end
      M_NAME: begin
        if (!name_ch) begin
          tok_o[0] = mk_tok(K_NAME, '0, start_ext[15:0], len_ext[15:0], ERR_NONE);
          cnt_o = 2'd1; mode_o = M_IDLE; reproc = 1'b1;
        end
      end
      M_ERR: begin
        // skip until NUL
      end
      default: begin
        mode_o = M_IDLE; reproc = 1'b1;
      end
    endcase

    // idle-mode lexing, also for the character that closed a number or name
    if (reproc) begin
      if (is_space(ch_i)) begin
        // skipped
      end else if (ch_i == "0") begin
        mode_o = M_ZERO; acc_o = '0;
      end else if (is_dig(ch_i)) begin
        mode_o = M_DEC; acc_o = 64'(ch_i[3:0]);
      end else if (is_alpha(ch_i) || ch_i == "_") begin
        mode_o = M_NAME; start_o = pos_i;
      end else if (ch_i == 8'd0) begin
        tok_o[cnt_o[0]] = mk_tok(K_END, '0, '0, '0, ERR_NONE);
        cnt_o = cnt_o + 2'd1;
      end else if (op.hit) begin
        tok_o[cnt_o[0]] = mk_tok(op.kind, '0, '0, '0, ERR_NONE);
        cnt_o = cnt_o + 2'd1;
      end else begin
        tok_o[cnt_o[0]] = mk_tok(K_ERROR, '0, '0, '0, ERR_CHAR);
        cnt_o = cnt_o + 2'd1; mode_o = M_ERR; acc_o = '0;
      end
    end

    if (ch_i == 8'd0) begin
      mode_o = M_IDLE; acc_o = '0; pos_o = '0; start_o = '0;
    end else if (pos_i != PosMax) begin
      pos_o = pos_i + 1'b1;
    end

    if (cnt_o == 2'd2) begin
      tok_o[1].last = 1'b1;
    end else if (cnt_o == 2'd1) begin
      tok_o[0].last = 1'b1;
    end
  end

endmodule

[rtl/core/etl_fifo.sv]
// ----------------------------------------------------------------------------
// etl_fifo
// Result queue: takes zero, one or two tokens per cycle, hands out one while the reader is ready.
// ----------------------------------------------------------------------------
module etl_fifo import etl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  tok_t       tok_i [2],
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output tok_t       tok_o
);

  tok_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;
  // two free slots guarantee a worst-case push
  assign room_o  = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    wptr_d = wptr_q + FIFO_AW'(push_cnt_i);
    rptr_d = rptr_q + FIFO_AW'(pop);
    cnt_d  = cnt_q + FIFO_CW'(push_cnt_i) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= tok_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_q + FIFO_AW'(1)] <= tok_i[1];
    end
  end

endmodule

[rtl/core/expression_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// expression_token_lexer_unit
// Character-at-a-time lexer for C-style expressions, emitting token words.
// ----------------------------------------------------------------------------
// Throughput: 1 character per cycle; a character may emit 0, 1 or 2 tokens,
//   and the output drains 1 token per cycle while the sink is ready,
//   through a 4-entry result queue; the input stalls while the queue holds
//   more than two tokens.
// Reset: asynchronous, active low; mode idle, accumulator and position
//   zero, input register and result queue empty.
module expression_token_lexer_unit import etl_pkg::*; #(
  parameter int POSITION_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  etl_char_if.sink           ch_i,
  etl_token_if.source        tok_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] ch_q;

  // lexer state
  mode_e                     mode_q, mode_d;
  logic [63:0]               acc_q, acc_d;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [POSITION_WIDTH-1:0] start_q, start_d;

  logic [1:0] step_cnt;
  tok_t       step_tok [2];
  logic       room;
  logic       fire;
  tok_t       head;

  // the held character is lexed once the queue can take two tokens
  assign fire       = in_vld_q && room;
  assign ch_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (ch_i.ready) begin
      in_vld_q <= ch_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_i.ready && ch_i.valid) begin
      ch_q <= ch_i.ch;
    end
  end

  etl_step #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_step (
    .mode_i  (mode_q),
    .acc_i   (acc_q),
    .pos_i   (pos_q),
    .start_i (start_q),
    .ch_i    (ch_q),
    .mode_o  (mode_d),
    .acc_o   (acc_d),
    .pos_o   (pos_d),
    .start_o (start_d),
    .cnt_o   (step_cnt),
    .tok_o   (step_tok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      acc_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      start_q <= start_d;
    end
  end

  etl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (fire ? step_cnt : 2'd0),
    .tok_i      (step_tok),
    .room_o     (room),
    .valid_o    (tok_o.valid),
    .ready_i    (tok_o.ready),
    .tok_o      (head)
  );

  assign tok_o.token_kind   = head.kind;
  assign tok_o.number_value = head.number_value;
  assign tok_o.name_start   = head.name_start;
  assign tok_o.name_length  = head.name_length;
  assign tok_o.error_kind   = head.error_kind;
  assign tok_o.last         = head.last;

endmodule

[rtl/core/etl_checker.sv]
// ----------------------------------------------------------------------------
// etl_checker
// Port-level checks on the lexer's token stream, bound to the top level.
// ----------------------------------------------------------------------------
module etl_checker import etl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_i,
  input logic [63:0] number_value_i,
  input logic [15:0] name_length_i,
  input logic [2:0]  error_kind_i
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i)
      && $stable(number_value_i))
    else $error("token word changed while stalled");

  // nothing comes out in the cycle after reset is released
  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) && rst_ni |-> !out_valid_i)
    else $error("token word right after reset");

  // error code present exactly on error tokens
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((token_kind_i == K_ERROR) == (error_kind_i != ERR_NONE)))
    else $error("error code does not match token kind");

  // only numbers carry a value, only names a length
  a_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((token_kind_i == K_NUM) || (number_value_i == '0))
      && ((token_kind_i == K_NAME) || (name_length_i == '0)))
    else $error("payload set on wrong token kind");

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (tok_o.valid),
  .out_ready_i    (tok_o.ready),
  .token_kind_i   (tok_o.token_kind),
  .number_value_i (tok_o.number_value),
  .name_length_i  (tok_o.name_length),
  .error_kind_i   (tok_o.error_kind)
);
